@@ design/zero_crossing_phase_meter_defines.svh @@
// Assertion macros shared by the phase meter checker.
// Each macro expects clk and rst to be visible at the point of use.
`ifndef ZERO_CROSSING_PHASE_METER_DEFINES_SVH
`define ZERO_CROSSING_PHASE_METER_DEFINES_SVH

// Same-cycle implication.
`define ZCPM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ZCPM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/zcpm_pkg.sv @@
// Types and constants of the zero-crossing phase meter.
// Used by the phase unit, the top level and the checker; depends on nothing.
package zcpm_pkg;

  // Result field widths
  localparam int DELTA_W  = 24;
  localparam int PERIOD_W = 25;
  localparam int PHASE_W  = 16;
  localparam int REP_W    = 17;
  localparam int OFFSET_W = 16;

  // Counter extension wide enough for twice the widest counter
  localparam int CNT_EXT_W = 33;

  localparam logic [DELTA_W-1:0]  DELTA_MAX  = 24'd16777215;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX = 25'd33554431;

  // delta * 36000 = (delta * 1125) << 5
  localparam int             MUL_K_W   = 11;
  localparam logic [10:0]    MUL_K     = 11'd1125;
  localparam int             MUL_SHIFT = 5;
  localparam int             ACC_W     = DELTA_W + MUL_K_W;

  // Quotient is 17 bits; anything above that saturates anyway
  localparam int               QUOT_W    = 17;
  localparam int               STEP_CW   = 5;
  localparam logic [16:0]      RAW_MAX   = 17'd54000;
  localparam logic [16:0]      HALF_TURN = 17'd18000;
  localparam logic [16:0]      FULL_TURN = 17'd36000;

  // Configuration port
  localparam int                   ADDR_W       = 3;
  localparam logic                 REG_OFFSET   = 1'b0;
  localparam logic signed [15:0]   OFFSET_RESET = 16'sd200;

  typedef enum logic [2:0] {
    STEP_WAIT_LOW      = 3'd0,
    STEP_WAIT_HIGH     = 3'd1,
    STEP_COUNT_HIGH    = 3'd2,
    STEP_WAIT_RISE     = 3'd3,
    STEP_WAIT_SIG_LOW  = 3'd4,
    STEP_WAIT_SIG_HIGH = 3'd5
  } meas_step_t;

  typedef enum logic [2:0] {
    CALC_IDLE  = 3'd0,
    CALC_MUL   = 3'd1,
    CALC_CHECK = 3'd2,
    CALC_DIV   = 3'd3,
    CALC_DONE  = 3'd4
  } calc_state_t;

  typedef struct packed {
    logic start;
    logic take;
  } calc_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } calc_sts_t;

endpackage

@@ design/zero_crossing_phase_meter.sv @@
// Zero-crossing phase meter top level: tick sequencer, result register, APB offset.
// Depends on zcpm_pkg and zcpm_phase_calc.
//
//   channel  handshake                 payload
//   tick     tick_valid / tick_stall   ref_level, sig_level
//   result   result_valid / result_stall
//                                      period_count, delay_count, phase_centideg,
//                                      reported_centideg, out_of_range
//   config   APB psel/penable/pwrite   paddr, pwdata, prdata (offset at 0)
//
// A tick is taken every cycle while the phase unit is idle.
// The tick that closes a phase measurement starts the unit: the multiply, the range
// check, the divide and the done state hold tick_stall high (the divide is skipped
// when the quotient reaches 2^17 or the period is zero), and the done state lasts
// while the result register is full and stalled.
// Reset returns the sequencer to waiting for reference low, clears counters
// and the saturation flag, and loads the offset with 200.
module zero_crossing_phase_meter #(
  parameter int COUNT_BITS = 24
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 tick_valid,
  output logic                                 tick_stall,
  input  logic                                 ref_level,
  input  logic                                 sig_level,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic [zcpm_pkg::PERIOD_W-1:0]        period_count,
  output logic [zcpm_pkg::DELTA_W-1:0]         delay_count,
  output logic signed [zcpm_pkg::PHASE_W-1:0]  phase_centideg,
  output logic signed [zcpm_pkg::REP_W-1:0]    reported_centideg,
  output logic                                 out_of_range,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [zcpm_pkg::ADDR_W-1:0]          paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam int EXT_W = zcpm_pkg::CNT_EXT_W;

  zcpm_pkg::meas_step_t meas_step, meas_step_next;

  logic [COUNT_BITS-1:0]                tick_count, tick_count_next;
  logic [COUNT_BITS-1:0]                half_period, half_period_next;
  logic                                 sat_flag, sat_flag_next;
  logic signed [zcpm_pkg::OFFSET_W-1:0] offset;

  logic                  tick_take;
  logic                  emit;
  logic                  cnt_sat;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [EXT_W-1:0]      delta_ext;
  logic [EXT_W-1:0]      period_ext;
  logic                  delta_cap;
  logic                  period_cap;
  logic [zcpm_pkg::DELTA_W-1:0]  emit_delta;
  logic [zcpm_pkg::PERIOD_W-1:0] emit_period;
  logic                  emit_flag;

  zcpm_pkg::calc_ctl_t calc_ctl;
  zcpm_pkg::calc_sts_t calc_sts;
  logic [zcpm_pkg::PERIOD_W-1:0]        calc_period;
  logic [zcpm_pkg::DELTA_W-1:0]         calc_delta;
  logic signed [zcpm_pkg::PHASE_W-1:0]  calc_phase;
  logic                                 calc_flag;
  logic signed [zcpm_pkg::REP_W-1:0]    rep_value;
  logic                                 cfg_write;
  logic                                 reg_sel;

  assign tick_stall = calc_sts.busy;
  assign tick_take  = tick_valid & ~tick_stall;

  assign cnt_sat = (tick_count == CNT_MAX);
  assign cnt_inc = cnt_sat ? CNT_MAX : tick_count + 1'b1;

  always_comb begin
    meas_step_next   = meas_step;
    tick_count_next  = tick_count;
    half_period_next = half_period;
    sat_flag_next    = sat_flag;
    emit             = 1'b0;
    if (tick_take) begin
      unique case (meas_step)
        zcpm_pkg::STEP_WAIT_HIGH: begin
          if (ref_level) begin
            tick_count_next = '0;
            meas_step_next  = zcpm_pkg::STEP_COUNT_HIGH;
          end
        end
        zcpm_pkg::STEP_COUNT_HIGH: begin
          tick_count_next = cnt_inc;
          sat_flag_next   = sat_flag | cnt_sat;
          if (!ref_level) begin
            half_period_next = cnt_inc;
            meas_step_next   = zcpm_pkg::STEP_WAIT_RISE;
          end
        end
        zcpm_pkg::STEP_WAIT_RISE: begin
          if (ref_level) begin
            tick_count_next = '0;
            meas_step_next  = zcpm_pkg::STEP_WAIT_SIG_LOW;
          end
        end
        zcpm_pkg::STEP_WAIT_SIG_LOW: begin
          tick_count_next = cnt_inc;
          sat_flag_next   = sat_flag | cnt_sat;
          if (!sig_level) begin
            meas_step_next = zcpm_pkg::STEP_WAIT_SIG_HIGH;
          end
        end
        zcpm_pkg::STEP_WAIT_SIG_HIGH: begin
          tick_count_next = cnt_inc;
          sat_flag_next   = sat_flag | cnt_sat;
          if (sig_level) begin
            emit           = 1'b1;
            sat_flag_next  = 1'b0;
            meas_step_next = zcpm_pkg::STEP_WAIT_LOW;
          end
        end
        default: begin
          // also catches unused step codes
          meas_step_next = ref_level ? zcpm_pkg::STEP_WAIT_LOW : zcpm_pkg::STEP_WAIT_HIGH;
        end
      endcase
    end
  end

  // Clamp the measurement to the result field widths
  always_comb begin
    delta_ext   = EXT_W'(cnt_inc);
    period_ext  = EXT_W'(half_period) << 1;
    delta_cap   = delta_ext > EXT_W'(zcpm_pkg::DELTA_MAX);
    period_cap  = period_ext > EXT_W'(zcpm_pkg::PERIOD_MAX);
    emit_delta  = delta_cap ? zcpm_pkg::DELTA_MAX : delta_ext[zcpm_pkg::DELTA_W-1:0];
    emit_period = period_cap ? zcpm_pkg::PERIOD_MAX : period_ext[zcpm_pkg::PERIOD_W-1:0];
    emit_flag   = sat_flag | cnt_sat | delta_cap | period_cap;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      meas_step   <= zcpm_pkg::STEP_WAIT_LOW;
      tick_count  <= '0;
      half_period <= '0;
      sat_flag    <= 1'b0;
    end else begin
      meas_step   <= meas_step_next;
      tick_count  <= tick_count_next;
      half_period <= half_period_next;
      sat_flag    <= sat_flag_next;
    end
  end

  assign calc_ctl.start = emit;
  assign calc_ctl.take  = calc_sts.done & (~result_valid | ~result_stall);

  zcpm_phase_calc u_calc (
    .clk        (clk),
    .rst        (rst),
    .ctl        (calc_ctl),
    .op_delta   (emit_delta),
    .op_period  (emit_period),
    .op_flag    (emit_flag),
    .sts        (calc_sts),
    .res_period (calc_period),
    .res_delta  (calc_delta),
    .res_phase  (calc_phase),
    .res_flag   (calc_flag)
  );

  assign rep_value = zcpm_pkg::REP_W'(offset) - zcpm_pkg::REP_W'(calc_phase);

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (calc_ctl.take) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (calc_ctl.take) begin
      period_count      <= calc_period;
      delay_count       <= calc_delta;
      phase_centideg    <= calc_phase;
      reported_centideg <= rep_value;
      out_of_range      <= calc_flag;
    end
  end

  // APB offset register
  assign pready    = 1'b1;
  assign reg_sel   = (paddr[zcpm_pkg::ADDR_W-1] == zcpm_pkg::REG_OFFSET);
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset <= zcpm_pkg::OFFSET_RESET;
    end else if (cfg_write && reg_sel) begin
      offset <= pwdata[zcpm_pkg::OFFSET_W-1:0];
    end
  end

  assign prdata = reg_sel ? 32'(offset) : '0;

endmodule

@@ design/zcpm_phase_calc.sv @@
// Phase unit: bit-serial delta*36000, then restoring division by the period.
// Depends on zcpm_pkg.
module zcpm_phase_calc (
  input  logic                                 clk,
  input  logic                                 rst,
  input  zcpm_pkg::calc_ctl_t                  ctl,
  input  logic [zcpm_pkg::DELTA_W-1:0]         op_delta,
  input  logic [zcpm_pkg::PERIOD_W-1:0]        op_period,
  input  logic                                 op_flag,
  output zcpm_pkg::calc_sts_t                  sts,
  output logic [zcpm_pkg::PERIOD_W-1:0]        res_period,
  output logic [zcpm_pkg::DELTA_W-1:0]         res_delta,
  output logic signed [zcpm_pkg::PHASE_W-1:0]  res_phase,
  output logic                                 res_flag
);

  localparam int ACC_W  = zcpm_pkg::ACC_W;
  localparam int QUOT_W = zcpm_pkg::QUOT_W;
  localparam int PER_W  = zcpm_pkg::PERIOD_W;
  localparam int LOW_W  = QUOT_W - zcpm_pkg::MUL_SHIFT;
  localparam int HI_W   = ACC_W - LOW_W;

  zcpm_pkg::calc_state_t state, state_next;

  logic [zcpm_pkg::STEP_CW-1:0]  bit_cnt;
  logic [ACC_W-1:0]              acc;
  logic [PER_W-1:0]              rem;
  logic [QUOT_W-1:0]             num;
  logic [QUOT_W-1:0]             quot;
  logic                          ovf;
  logic [zcpm_pkg::DELTA_W-1:0]  delta_r;
  logic [PER_W-1:0]              period_r;
  logic                          flag_r;

  logic [ACC_W-1:0]  acc_add;
  logic [PER_W-1:0]  hi_part;
  logic              hi_ovf;
  logic [PER_W:0]    rem_sh;
  logic              rem_ge;
  logic [PER_W:0]    rem_sub;
  logic              last_bit;
  logic              raw_sat;
  logic [QUOT_W-1:0] raw;
  logic [QUOT_W-1:0] phase_wide;

  assign acc_add  = zcpm_pkg::MUL_K[bit_cnt[3:0]] ? ACC_W'(delta_r) : '0;
  assign hi_part  = PER_W'(acc[ACC_W-1:LOW_W]);
  assign hi_ovf   = (hi_part >= period_r);
  assign rem_sh   = {rem, num[QUOT_W-1]};
  assign rem_ge   = (rem_sh >= {1'b0, period_r});
  assign rem_sub  = rem_sh - {1'b0, period_r};
  assign last_bit = (bit_cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= zcpm_pkg::CALC_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    sts.busy   = 1'b1;
    sts.done   = 1'b0;
    unique case (state)
      zcpm_pkg::CALC_IDLE: begin
        sts.busy = 1'b0;
        if (ctl.start) begin
          state_next = zcpm_pkg::CALC_MUL;
        end
      end
      zcpm_pkg::CALC_MUL: begin
        if (last_bit) begin
          state_next = zcpm_pkg::CALC_CHECK;
        end
      end
      zcpm_pkg::CALC_CHECK: begin
        state_next = hi_ovf ? zcpm_pkg::CALC_DONE : zcpm_pkg::CALC_DIV;
      end
      zcpm_pkg::CALC_DIV: begin
        if (last_bit) begin
          state_next = zcpm_pkg::CALC_DONE;
        end
      end
      zcpm_pkg::CALC_DONE: begin
        sts.done = 1'b1;
        if (ctl.take) begin
          state_next = zcpm_pkg::CALC_IDLE;
        end
      end
      default: begin
        state_next = zcpm_pkg::CALC_IDLE;
      end
    endcase
  end

  // Datapath
  always_ff @(posedge clk) begin
    unique case (state)
      zcpm_pkg::CALC_IDLE: begin
        if (ctl.start) begin
          delta_r  <= op_delta;
          period_r <= op_period;
          flag_r   <= op_flag;
          acc      <= '0;
          bit_cnt  <= zcpm_pkg::STEP_CW'(zcpm_pkg::MUL_K_W - 1);
        end
      end
      zcpm_pkg::CALC_MUL: begin
        acc <= {acc[ACC_W-2:0], 1'b0} + acc_add;
        if (!last_bit) begin
          bit_cnt <= bit_cnt - 1'b1;
        end
      end
      zcpm_pkg::CALC_CHECK: begin
        // quotient of 2^17 or more (or a zero period) saturates at once
        ovf     <= hi_ovf;
        rem     <= hi_part;
        num     <= {acc[LOW_W-1:0], zcpm_pkg::MUL_SHIFT'(0)};
        quot    <= '0;
        bit_cnt <= zcpm_pkg::STEP_CW'(QUOT_W - 1);
      end
      zcpm_pkg::CALC_DIV: begin
        rem  <= rem_ge ? rem_sub[PER_W-1:0] : rem_sh[PER_W-1:0];
        num  <= {num[QUOT_W-2:0], 1'b0};
        quot <= {quot[QUOT_W-2:0], rem_ge};
        if (!last_bit) begin
          bit_cnt <= bit_cnt - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Saturate the ratio and wrap it into the half turn around zero
  always_comb begin
    raw_sat    = ovf || (quot > zcpm_pkg::RAW_MAX);
    raw        = raw_sat ? zcpm_pkg::RAW_MAX : quot;
    phase_wide = (raw > zcpm_pkg::HALF_TURN) ? (raw - zcpm_pkg::FULL_TURN) : raw;
  end

  assign res_period = period_r;
  assign res_delta  = delta_r;
  assign res_phase  = phase_wide[zcpm_pkg::PHASE_W-1:0];
  assign res_flag   = flag_r | raw_sat;

endmodule

@@ design/zcpm_checker.sv @@
// Port-level checker for the zero-crossing phase meter, bound to the top level.
// Depends on zcpm_pkg and zero_crossing_phase_meter_defines.svh.
`include "zero_crossing_phase_meter_defines.svh"

module zcpm_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 tick_stall,
  input logic                                 result_valid,
  input logic                                 result_stall,
  input logic [zcpm_pkg::PERIOD_W-1:0]        period_count,
  input logic [zcpm_pkg::DELTA_W-1:0]         delay_count,
  input logic signed [zcpm_pkg::PHASE_W-1:0]  phase_centideg,
  input logic signed [zcpm_pkg::REP_W-1:0]    reported_centideg,
  input logic                                 out_of_range
);

  logic [zcpm_pkg::PERIOD_W+zcpm_pkg::DELTA_W+zcpm_pkg::PHASE_W+zcpm_pkg::REP_W:0] payload;
  logic res_held;
  logic res_clean;
  logic phase_in_range;

  assign payload        = {period_count, delay_count, phase_centideg, reported_centideg,
                           out_of_range};
  assign res_held       = result_valid && result_stall;
  assign res_clean      = result_valid && !out_of_range;
  assign phase_in_range = (phase_centideg >= -18000) && (phase_centideg <= 18000);

  `ZCPM_ASSERT_NEXT(a_result_held, res_held, result_valid, "result dropped while stalled")

  `ZCPM_ASSERT_NEXT(a_payload_held, res_held, $stable(payload), "stalled result changed")

  `ZCPM_ASSERT_NOW(a_phase_range, result_valid, phase_in_range, "phase outside half turn")

  `ZCPM_ASSERT_NOW(a_zero_period, res_clean, period_count != '0, "zero period unflagged")

  `ZCPM_ASSERT_NOW(a_stall_first, $rose(result_valid), $past(tick_stall), "unstalled result")

endmodule

bind zero_crossing_phase_meter zcpm_checker u_checker (
  .clk               (clk),
  .rst               (rst),
  .tick_stall        (tick_stall),
  .result_valid      (result_valid),
  .result_stall      (result_stall),
  .period_count      (period_count),
  .delay_count       (delay_count),
  .phase_centideg    (phase_centideg),
  .reported_centideg (reported_centideg),
  .out_of_range      (out_of_range)
);

@@ dv/zero_crossing_phase_meter_tb.sv @@
`timescale 1ns / 1ps
// Testbench for zero_crossing_phase_meter: drives comparator ticks, writes the offset over APB
// and checks every phase reading against a tick-level predictor. Depends on zcpm_pkg and the RTL.
module zero_crossing_phase_meter_tb;

  localparam int COUNT_BITS = 24;
  localparam longint unsigned COUNT_CAP  = (64'd1 << COUNT_BITS) - 1;
  localparam longint unsigned PERIOD_CAP = 64'd33554431;
  localparam longint unsigned DELTA_CAP  = 64'd16777215;
  localparam longint unsigned RAW_CAP    = 64'd54000;
  localparam int SETTLE_CYCLES = 64;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam logic [zcpm_pkg::ADDR_W-1:0] OFFSET_ADDR =
    zcpm_pkg::ADDR_W'(4 * zcpm_pkg::REG_OFFSET);

  // {ref_level, sig_level}: a boundary phase, a negative phase and a saturated ratio
  localparam logic [1:0] OPENING [0:25] = '{
    2'b11, 2'b01, 2'b10, 2'b00, 2'b11, 2'b11, 2'b00, 2'b01,
    2'b00, 2'b10, 2'b10, 2'b10, 2'b00, 2'b11, 2'b11, 2'b11, 2'b10, 2'b11,
    2'b00, 2'b10, 2'b00, 2'b10, 2'b11, 2'b11, 2'b10, 2'b11
  };

  typedef struct {
    logic [24:0]        period_count;
    logic [23:0]        delay_count;
    logic signed [15:0] phase_centideg;
    logic signed [16:0] reported_centideg;
    logic               out_of_range;
  } reading_t;

  class phase_tracker;
    zcpm_pkg::meas_step_t step;
    longint unsigned count;
    longint unsigned half;
    bit              sat;
    int              offset;
    reading_t        readings[$];
    int              ticks_taken;
    int              readings_made;
    int              mismatches;

    function new();
      step = zcpm_pkg::STEP_WAIT_LOW;
      count = 0;
      half = 0;
      sat = 0;
      offset = 200;
      ticks_taken = 0;
      readings_made = 0;
      mismatches = 0;
    endfunction

    function void set_offset(logic [15:0] value);
      offset = $signed(value);
    endfunction

    function void bump();
      if (count >= COUNT_CAP) begin
        count = COUNT_CAP;
        sat = 1;
      end else begin
        count++;
      end
    endfunction

    function void take_tick(logic ref_in, logic sig_in);
      reading_t        rd;
      longint unsigned per;
      longint unsigned dlt;
      longint unsigned raw;
      int              ph;
      int              rv;
      bit              flag;
      ticks_taken++;
      case (step)
        zcpm_pkg::STEP_WAIT_HIGH: begin
          if (ref_in) begin
            count = 0;
            step = zcpm_pkg::STEP_COUNT_HIGH;
          end
        end
        zcpm_pkg::STEP_COUNT_HIGH: begin
          bump();
          if (!ref_in) begin
            half = count;
            step = zcpm_pkg::STEP_WAIT_RISE;
          end
        end
        zcpm_pkg::STEP_WAIT_RISE: begin
          if (ref_in) begin
            count = 0;
            step = zcpm_pkg::STEP_WAIT_SIG_LOW;
          end
        end
        zcpm_pkg::STEP_WAIT_SIG_LOW: begin
          bump();
          if (!sig_in) step = zcpm_pkg::STEP_WAIT_SIG_HIGH;
        end
        zcpm_pkg::STEP_WAIT_SIG_HIGH: begin
          bump();
          if (sig_in) begin
            per = 2 * half;
            dlt = count;
            flag = sat;
            if (per > PERIOD_CAP) begin
              per = PERIOD_CAP;
              flag = 1;
            end
            if (dlt > DELTA_CAP) begin
              dlt = DELTA_CAP;
              flag = 1;
            end
            if (per == 0) begin
              raw = RAW_CAP;
              flag = 1;
            end else begin
              raw = dlt * 36000 / per;
              if (raw > RAW_CAP) begin
                raw = RAW_CAP;
                flag = 1;
              end
            end
            ph = int'(raw);
            // wrap to the half turn around zero
            if (ph > 18000) ph -= 36000;
            rv = offset - ph;
            rd.period_count = per[24:0];
            rd.delay_count = dlt[23:0];
            rd.phase_centideg = 16'(ph);
            rd.reported_centideg = 17'(rv);
            rd.out_of_range = flag;
            readings.push_back(rd);
            readings_made++;
            sat = 0;
            step = zcpm_pkg::STEP_WAIT_LOW;
          end
        end
        default: step = ref_in ? zcpm_pkg::STEP_WAIT_LOW : zcpm_pkg::STEP_WAIT_HIGH;
      endcase
    endfunction

    function void match_reading(reading_t got);
      reading_t want;
      if (readings.size() == 0) begin
        $error("reading arrived with none pending");
        mismatches++;
        return;
      end
      want = readings.pop_front();
      if (got.period_count !== want.period_count) begin
        $error("period_count: expected %0d, actual %0d", want.period_count, got.period_count);
        mismatches++;
      end
      if (got.delay_count !== want.delay_count) begin
        $error("delay_count: expected %0d, actual %0d", want.delay_count, got.delay_count);
        mismatches++;
      end
      if (got.phase_centideg !== want.phase_centideg) begin
        $error("phase_centideg: expected %0d, actual %0d",
               want.phase_centideg, got.phase_centideg);
        mismatches++;
      end
      if (got.reported_centideg !== want.reported_centideg) begin
        $error("reported_centideg: expected %0d, actual %0d",
               want.reported_centideg, got.reported_centideg);
        mismatches++;
      end
      if (got.out_of_range !== want.out_of_range) begin
        $error("out_of_range: expected %0d, actual %0d", want.out_of_range, got.out_of_range);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic tick_valid;
  logic tick_stall;
  logic ref_level;
  logic sig_level;
  logic result_valid;
  logic result_stall;
  logic [zcpm_pkg::PERIOD_W-1:0] period_count;
  logic [zcpm_pkg::DELTA_W-1:0] delay_count;
  logic signed [zcpm_pkg::PHASE_W-1:0] phase_centideg;
  logic signed [zcpm_pkg::REP_W-1:0] reported_centideg;
  logic out_of_range;
  logic psel;
  logic penable;
  logic pwrite;
  logic [zcpm_pkg::ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  phase_tracker tracker;
  bit calm;
  int cycles;

  zero_crossing_phase_meter #(
    .COUNT_BITS(COUNT_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .tick_valid(tick_valid),
    .tick_stall(tick_stall),
    .ref_level(ref_level),
    .sig_level(sig_level),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .period_count(period_count),
    .delay_count(delay_count),
    .phase_centideg(phase_centideg),
    .reported_centideg(reported_centideg),
    .out_of_range(out_of_range),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Offer one tick item and hold it until the block takes it.
  task automatic send_tick(input logic ref_in, input logic sig_in);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 10);
    @(negedge clk);
    if (gap > 0) begin
      tick_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    tick_valid <= 1'b1;
    ref_level <= ref_in;
    sig_level <= sig_in;
    do @(posedge clk); while (tick_stall);
    tracker.take_tick(ref_in, sig_in);
  endtask

  // Drop the tick channel and wait until every reading is out and the unit is quiet.
  task automatic settle();
    @(negedge clk);
    tick_valid <= 1'b0;
    while (tracker.readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_offset(input logic [15:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= OFFSET_ADDR;
    pwdata <= {16'($urandom()), value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.set_offset(value);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Reading side: stall a random number of valid cycles before taking each item.
  initial begin
    reading_t got;
    int hold;
    result_stall = 1'b0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid) begin
        if (!result_stall) begin
          got.period_count = period_count;
          got.delay_count = delay_count;
          got.phase_centideg = phase_centideg;
          got.reported_centideg = reported_centideg;
          got.out_of_range = out_of_range;
          tracker.match_reading(got);
          hold = calm ? 0 : $urandom_range(0, 10);
        end else if (hold > 0) begin
          hold--;
        end
      end
      @(negedge clk);
      result_stall <= (hold > 0);
    end
  end

  initial begin
    logic [15:0] offsets [0:8];
    int tick_mark;
    int reading_mark;
    int hr;
    int lr;
    int per;
    int sper;
    int hs;
    int ro;
    int so;
    int n;
    tracker = new();
    cycles = 0;
    calm = 0;
    rst = 1'b1;
    tick_valid = 1'b0;
    ref_level = 1'b0;
    sig_level = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Opening items run with the offset left at its reset value.
    foreach (OPENING[i]) send_tick(OPENING[i][1], OPENING[i][0]);

    offsets[0] = -16'sd18000;
    offsets[1] = 16'sd18000;
    offsets[2] = 16'sd0;
    offsets[3] = 16'h8000;
    offsets[4] = 16'h7fff;
    for (int i = 5; i < 9; i++) offsets[i] = 16'($urandom());

    for (int k = 0; k < 9; k++) begin
      settle();
      calm = (k % 3 == 2);
      write_offset(offsets[k]);
      tick_mark = tracker.ticks_taken;
      reading_mark = tracker.readings_made;
      while (tracker.ticks_taken - tick_mark < 200 || tracker.readings_made - reading_mark < 5)
      begin
        if ($urandom_range(0, 4) == 0) begin
          // broken comparator chatter
          n = $urandom_range(4, 30);
          repeat (n) send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else begin
          if ($urandom_range(0, 39) == 0) begin
            hr = $urandom_range(20, 60);
            lr = $urandom_range(20, 60);
          end else begin
            hr = $urandom_range(1, 12);
            lr = $urandom_range(1, 12);
          end
          per = hr + lr;
          sper = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 3 * per) : per;
          hs = $urandom_range(1, sper - 1);
          ro = $urandom_range(0, per - 1);
          so = $urandom_range(0, sper - 1);
          n = per * $urandom_range(3, 6);
          for (int t = 0; t < n; t++) begin
            send_tick(((t + ro) % per) < hr, ((t + so) % sper) < hs);
          end
        end
      end
    end

    settle();
    if (tracker.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
